[hw/rtl/packet_frame_multiplexer_assert.svh]
// ----------------------------------------------------------------------------
// Packet frame multiplexer assertion macros
// Concurrent assertion shorthands sampled on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PACKET_FRAME_MULTIPLEXER_ASSERT_SVH
`define PACKET_FRAME_MULTIPLEXER_ASSERT_SVH

// Same-cycle implication.
`define PFM_ASSERT_IMP(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("packet frame multiplexer check failed");

// Next-cycle implication.
`define PFM_ASSERT_NXT(name, ante, cons) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("packet frame multiplexer check failed");

`endif

[hw/rtl/pfm_pkg.sv]
// ----------------------------------------------------------------------------
// pfm_pkg
// Shared constants and types of the packet frame multiplexer.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pfm_pkg;

  localparam int FRAME_BYTES_DEF = 256;
  localparam int MIN_START_ROOM  = 2;

  localparam logic [31:0] LFSR_MASK  = 32'h8020_0003;
  localparam logic [31:0] SEED_RESET = 32'h0000_0001;

  // Input word action codes.
  localparam logic ACT_BYTE = 1'b0;
  localparam logic ACT_IDLE = 1'b1;

  typedef struct packed {
    logic load;
    logic step;
  } noise_ctl_t;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        byte_taken;
    logic        frame_end;
    logic [15:0] frame_count;
    logic        first_valid;
    logic [7:0]  first_offset;
    logic        last_valid;
    logic [7:0]  last_offset;
    logic        underrun;
  } result_t;

endpackage

[hw/rtl/pfm_in_if.sv]
// ----------------------------------------------------------------------------
// pfm_in_if
// Input channel: one frame slot request word with valid/ready handshake.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfm_in_if;
  logic       valid;
  logic       ready;
  logic       action;
  logic [7:0] packet_byte;
  logic       packet_end;

  modport source (output valid, output action, output packet_byte, output packet_end,
                  input ready);
  modport sink   (input valid, input action, input packet_byte, input packet_end,
                  output ready);
endinterface

[hw/rtl/pfm_out_if.sv]
// ----------------------------------------------------------------------------
// pfm_out_if
// Result channel: one frame content word with header fields on frame end.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

interface pfm_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        byte_taken;
  logic        frame_end;
  logic [15:0] frame_count;
  logic        first_valid;
  logic [7:0]  first_offset;
  logic        last_valid;
  logic [7:0]  last_offset;
  logic        underrun;

  modport source (output valid, output out_byte, output byte_taken, output frame_end,
                  output frame_count, output first_valid, output first_offset,
                  output last_valid, output last_offset, output underrun,
                  input ready);
  modport sink   (input valid, input out_byte, input byte_taken, input frame_end,
                  input frame_count, input first_valid, input first_offset,
                  input last_valid, input last_offset, input underrun,
                  output ready);
endinterface

[hw/rtl/pfm_noise_lfsr.sv]
// ----------------------------------------------------------------------------
// pfm_noise_lfsr
// 32-bit Galois LFSR that supplies noise bytes for padding slots.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfm_noise_lfsr (
  input  logic               clk,
  input  logic               rst_n,
  input  pfm_pkg::noise_ctl_t ctl,
  input  logic [31:0]        seed,
  output logic [7:0]         noise_byte
);

  logic [31:0] lfsr_r;
  logic [31:0] lfsr_nxt;
  logic [31:0] lfsr_step;

  // The noise byte is the low byte of the state after one step.
  assign lfsr_step  = lfsr_r[0] ? ((lfsr_r >> 1) ^ pfm_pkg::LFSR_MASK) : (lfsr_r >> 1);
  assign noise_byte = lfsr_step[7:0];

  always_comb begin
    lfsr_nxt = lfsr_r;
    if (ctl.load) begin
      // A zero seed would lock the register up, so it is loaded as one.
      lfsr_nxt = (seed != 32'd0) ? seed : pfm_pkg::SEED_RESET;
    end else if (ctl.step) begin
      lfsr_nxt = lfsr_step;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lfsr_r <= pfm_pkg::SEED_RESET;
    end else begin
      lfsr_r <= lfsr_nxt;
    end
  end

endmodule

[hw/rtl/pfm_framer.sv]
// ----------------------------------------------------------------------------
// pfm_framer
// Frame slot decision logic and per-frame bookkeeping registers.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pfm_framer #(
  parameter int FRAME_BYTES = pfm_pkg::FRAME_BYTES_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                fire,
  input  logic                action,
  input  logic [7:0]          packet_byte,
  input  logic                packet_end,
  input  logic [7:0]          noise_byte,
  output pfm_pkg::noise_ctl_t noise_ctl_o,
  output pfm_pkg::result_t    result
);

  localparam int POS_W = $clog2(FRAME_BYTES);
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(FRAME_BYTES - 1);
  localparam logic [POS_W-1:0] POS_ROOM = POS_W'(FRAME_BYTES - pfm_pkg::MIN_START_ROOM);

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [15:0]      frame_num_r, frame_num_nxt;
  logic             inside_r, inside_nxt;
  logic             pad_r, pad_nxt;
  logic [7:0]       first_start_r, first_start_nxt;
  logic             first_seen_r, first_seen_nxt;
  logic [7:0]       last_start_r, last_start_nxt;
  logic             last_seen_r, last_seen_nxt;
  logic             step;
  logic             fend;
  logic             idle;

  assign idle = (action == pfm_pkg::ACT_IDLE);
  assign fend = (pos_r == POS_LAST);

  always_comb begin
    pos_nxt         = pos_r;
    frame_num_nxt   = frame_num_r;
    inside_nxt      = inside_r;
    pad_nxt         = pad_r;
    first_start_nxt = first_start_r;
    first_seen_nxt  = first_seen_r;
    last_start_nxt  = last_start_r;
    last_seen_nxt   = last_seen_r;
    step            = 1'b0;
    result          = '0;

    if (pad_r) begin
      step = 1'b1;
      result.out_byte = noise_byte;
    end else if (inside_r) begin
      if (!idle) begin
        result.out_byte   = packet_byte;
        result.byte_taken = 1'b1;
        if (packet_end) begin
          inside_nxt = 1'b0;
        end
      end else begin
        // Upstream ran dry in mid-packet; the packet stays open.
        step = 1'b1;
        result.out_byte = noise_byte;
        result.underrun = 1'b1;
      end
    end else if (pos_r > POS_ROOM || idle) begin
      pad_nxt = 1'b1;
      step    = 1'b1;
      result.out_byte = noise_byte;
    end else begin
      if (!first_seen_r) begin
        first_seen_nxt  = 1'b1;
        first_start_nxt = 8'(pos_r);
      end
      last_seen_nxt     = 1'b1;
      last_start_nxt    = 8'(pos_r);
      result.out_byte   = packet_byte;
      result.byte_taken = 1'b1;
      inside_nxt        = !packet_end;
    end

    result.frame_end = fend;
    if (fend) begin
      result.frame_count  = frame_num_r;
      result.first_valid  = first_seen_nxt;
      result.first_offset = first_seen_nxt ? first_start_nxt : 8'd0;
      result.last_valid   = last_seen_nxt;
      result.last_offset  = last_seen_nxt ? last_start_nxt : 8'd0;
      frame_num_nxt   = frame_num_r + 16'd1;
      pos_nxt         = '0;
      pad_nxt         = 1'b0;
      first_seen_nxt  = 1'b0;
      first_start_nxt = 8'd0;
      last_seen_nxt   = 1'b0;
      last_start_nxt  = 8'd0;
    end else begin
      pos_nxt = pos_r + POS_W'(1);
    end
  end

  assign noise_ctl_o.load = 1'b0;
  assign noise_ctl_o.step = fire && step;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r         <= '0;
      frame_num_r   <= 16'd0;
      inside_r      <= 1'b0;
      pad_r         <= 1'b0;
      first_start_r <= 8'd0;
      first_seen_r  <= 1'b0;
      last_start_r  <= 8'd0;
      last_seen_r   <= 1'b0;
    end else if (fire) begin
      pos_r         <= pos_nxt;
      frame_num_r   <= frame_num_nxt;
      inside_r      <= inside_nxt;
      pad_r         <= pad_nxt;
      first_start_r <= first_start_nxt;
      first_seen_r  <= first_seen_nxt;
      last_start_r  <= last_start_nxt;
      last_seen_r   <= last_seen_nxt;
    end
  end

endmodule

[hw/rtl/packet_frame_multiplexer.sv]
// ----------------------------------------------------------------------------
// packet_frame_multiplexer
// Packs packet bytes into fixed frames, one slot per word, with header info.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake        Payload
//   in_chan   sink       valid / ready    action, packet_byte, packet_end
//   out_chan  source     valid / ready    out_byte .. underrun (one per slot)
//   cfg_      write      cfg_we           cfg_wdata = noise seed
//
// Every input word yields exactly one result word. An accepted word waits in
// the input register, and its result is registered into the result register
// when that register is empty or being drained. One word per clock is
// sustained while out_chan is not stalled: the slot logic is a single pass
// between the input register and the result register. Reset is synchronous
// on rst_n; the noise generator then holds seed one. A stall on out_chan
// holds the result register, and the input register still absorbs one more
// word.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module packet_frame_multiplexer #(
  parameter int FRAME_BYTES = pfm_pkg::FRAME_BYTES_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  pfm_in_if.sink      in_chan,
  pfm_out_if.source   out_chan,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);

  // Input register stage.
  logic       s1_valid_r;
  logic       s1_action_r;
  logic [7:0] s1_byte_r;
  logic       s1_end_r;
  logic       s1_adv;
  logic       in_fire;

  // Result register stage.
  logic             out_valid_r;
  pfm_pkg::result_t out_r;
  pfm_pkg::result_t result;

  pfm_pkg::noise_ctl_t framer_ctl;
  pfm_pkg::noise_ctl_t noise_ctl;
  logic [7:0]          noise_byte;

  // The word in the input register moves on whenever the result register is
  // empty or being drained this cycle.
  assign s1_adv          = !out_valid_r || out_chan.ready;
  assign in_chan.ready   = !s1_valid_r || s1_adv;
  assign in_fire         = in_chan.valid && in_chan.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_chan.ready) begin
      s1_valid_r <= in_chan.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_action_r <= in_chan.action;
      s1_byte_r   <= in_chan.packet_byte;
      s1_end_r    <= in_chan.packet_end;
    end
  end

  pfm_framer #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_framer (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (s1_valid_r && s1_adv),
    .action      (s1_action_r),
    .packet_byte (s1_byte_r),
    .packet_end  (s1_end_r),
    .noise_byte  (noise_byte),
    .noise_ctl_o (framer_ctl),
    .result      (result)
  );

  // A seed write reloads the generator at once; user writes only while idle, unenforced.
  assign noise_ctl.load = cfg_we;
  assign noise_ctl.step = framer_ctl.step;

  pfm_noise_lfsr u_noise (
    .clk        (clk),
    .rst_n      (rst_n),
    .ctl        (noise_ctl),
    .seed       (cfg_wdata),
    .noise_byte (noise_byte)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_adv) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && s1_adv) begin
      out_r <= result;
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.out_byte     = out_r.out_byte;
  assign out_chan.byte_taken   = out_r.byte_taken;
  assign out_chan.frame_end    = out_r.frame_end;
  assign out_chan.frame_count  = out_r.frame_count;
  assign out_chan.first_valid  = out_r.first_valid;
  assign out_chan.first_offset = out_r.first_offset;
  assign out_chan.last_valid   = out_r.last_valid;
  assign out_chan.last_offset  = out_r.last_offset;
  assign out_chan.underrun     = out_r.underrun;

`include "packet_frame_multiplexer_assert.svh"

  // A consumed packet byte is never also an underrun slot.
  `PFM_ASSERT_IMP(a_taken_not_underrun, out_valid_r && out_r.byte_taken, !out_r.underrun)
  // Header fields stay zero except on the last slot of a frame.
  `PFM_ASSERT_IMP(a_header_only_at_end, out_valid_r && !out_r.frame_end,
                  out_r.frame_count == 16'd0 && !out_r.first_valid && !out_r.last_valid)
  // First and last packet starts are recorded together.
  `PFM_ASSERT_IMP(a_first_last_pair, out_valid_r, out_r.first_valid == out_r.last_valid)
  // A word held in the input register is not lost while the output stalls.
  `PFM_ASSERT_NXT(a_s1_holds, s1_valid_r && !s1_adv,
                  s1_valid_r && $stable(s1_byte_r) && $stable(s1_action_r))

endmodule
